[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define TRPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TRPS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/trps_pkg.sv]
// Shared constants, types and register codes of the trapezoidal pulse shaper.
// No dependencies.
`default_nettype none

package trps_pkg;

  localparam int MAX_DELAY   = 512;
  localparam int SAMPLE_BITS = 16;
  localparam int IN_W        = 16;
  localparam int LINE_DEPTH  = 2 * MAX_DELAY;
  localparam int ADDR_W      = $clog2(LINE_DEPTH);
  localparam int DIST_W      = ADDR_W + 1;

  localparam int LEN_W = 10;
  localparam int M_W   = 24;
  localparam int G_W   = 24;
  localparam int Y_W   = 32;
  localparam int P_W   = 40;
  localparam int S_W   = 56;

  localparam int DIFF_W = SAMPLE_BITS + 2;
  localparam int PROD_W = DIFF_W + M_W + 1;
  localparam int INC_W  = P_W + 9;
  localparam int HI_W   = S_W - 32;
  localparam int MHI_W  = HI_W + G_W + 1;
  localparam int MLO_W  = 32 + G_W;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_RISE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd4;

  localparam logic [LEN_W-1:0] RISE_RST  = 10'd16;
  localparam logic [LEN_W-1:0] GAP_RST   = 10'd32;
  localparam logic [M_W-1:0]   DECAY_RST = 24'd25600;
  localparam logic [G_W-1:0]   GAIN_RST  = 24'd16384;

  typedef struct packed {
    logic [LEN_W-1:0] rise;
    logic [LEN_W-1:0] gap;
    logic [M_W-1:0]   decay;
    logic             step;
    logic [G_W-1:0]   gain;
  } cfg_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic                     sor;
  } op_t;

endpackage

`default_nettype wire

[hdl/trps_if.sv]
// Valid/ready channel interfaces for samples and shaped results.
// Depends on trps_pkg.
`default_nettype none

interface trps_in_if;
  logic                          valid;
  logic                          ready;
  logic [trps_pkg::IN_W-1:0]     sample;
  logic                          start_of_record;

  modport source (output valid, output sample, output start_of_record, input ready);
  modport sink (input valid, input sample, input start_of_record, output ready);
endinterface

interface trps_out_if;
  logic                          valid;
  logic                          ready;
  logic [trps_pkg::Y_W-1:0]      shaped;
  logic                          saturated;

  modport source (output valid, output shaped, output saturated, input ready);
  modport sink (input valid, input shaped, input saturated, output ready);
endinterface

`default_nettype wire

[hdl/trps_front.sv]
// Front end: accepts samples, keeps the delay line and forms the tap difference.
// Depends on trps_pkg and trps_in_if.
`default_nettype none

module trps_front (
  input  logic            clk,
  input  logic            rst_n,
  trps_in_if.sink         in_ch,
  input  trps_pkg::cfg_t  cfg,
  output logic            push_valid,
  input  logic            push_ready,
  output trps_pkg::op_t   push_op
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_RD0  = 3'd1;
  localparam logic [2:0] F_RD1  = 3'd2;
  localparam logic [2:0] F_RD2  = 3'd3;
  localparam logic [2:0] F_ADD  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  localparam logic [1:0] TAP_CUR   = 2'd0;
  localparam logic [1:0] TAP_FIRST = 2'd1;
  localparam logic [1:0] TAP_MEM   = 2'd2;

  localparam int SB = trps_pkg::SAMPLE_BITS;
  localparam int DW = trps_pkg::DIFF_W;
  localparam int AW = trps_pkg::ADDR_W;
  localparam int TW = trps_pkg::DIST_W;

  logic [2:0]           state_r, state_nxt;
  logic signed [SB-1:0] x_r, x_nxt;
  logic signed [SB-1:0] first_r, first_nxt;
  logic [TW-1:0]        seen_r, seen_nxt;
  logic [AW-1:0]        wptr_r, wptr_nxt;
  logic signed [DW-1:0] diff_r, diff_nxt;
  logic                 sor_r, sor_nxt;
  logic [1:0]           sel_r, sel_nxt;
  logic [SB-1:0]        rdata_r;
  logic [SB-1:0]        mem [trps_pkg::LINE_DEPTH];

  logic [TW-1:0]        k_eff, l_eff, kl_eff, tap_dist;
  logic [AW-1:0]        rd_addr;
  logic signed [SB-1:0] tap_v;
  logic signed [DW-1:0] tap_x;
  logic signed [SB-1:0] in_x;
  logic                 accept, mem_we;

  assign k_eff  = (TW'(cfg.rise) > TW'(trps_pkg::MAX_DELAY)) ? TW'(trps_pkg::MAX_DELAY)
                                                              : TW'(cfg.rise);
  assign l_eff  = (TW'(cfg.gap) > TW'(trps_pkg::MAX_DELAY)) ? TW'(trps_pkg::MAX_DELAY)
                                                             : TW'(cfg.gap);
  assign kl_eff = k_eff + l_eff;

  assign in_ch.ready = (state_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_x        = $signed(in_ch.sample[SB-1:0]);

  always_comb begin
    unique case (state_r)
      F_RD1:   tap_dist = l_eff;
      F_RD2:   tap_dist = kl_eff;
      default: tap_dist = k_eff;
    endcase
  end

  assign rd_addr = wptr_r - tap_dist[AW-1:0];

  always_comb begin
    if (tap_dist == '0) begin
      sel_nxt = TAP_CUR;
    end else if (tap_dist > seen_r) begin
      sel_nxt = TAP_FIRST;
    end else begin
      sel_nxt = TAP_MEM;
    end
  end

  always_comb begin
    case (sel_r)
      TAP_CUR:   tap_v = x_r;
      TAP_FIRST: tap_v = first_r;
      default:   tap_v = $signed(rdata_r);
    endcase
  end

  assign tap_x = DW'(tap_v);

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    first_nxt  = first_r;
    seen_nxt   = seen_r;
    wptr_nxt   = wptr_r;
    diff_nxt   = diff_r;
    sor_nxt    = sor_r;
    push_valid = 1'b0;
    mem_we     = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          x_nxt    = in_x;
          diff_nxt = DW'(in_x);
          sor_nxt  = in_ch.start_of_record;
          if (in_ch.start_of_record) begin
            first_nxt = in_x;
            seen_nxt  = '0;
          end
          state_nxt = F_RD0;
        end
      end
      F_RD0: state_nxt = F_RD1;
      F_RD1: begin
        diff_nxt  = diff_r - tap_x;
        state_nxt = F_RD2;
      end
      F_RD2: begin
        diff_nxt  = diff_r - tap_x;
        state_nxt = F_ADD;
      end
      F_ADD: begin
        diff_nxt  = diff_r + tap_x;
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          mem_we   = 1'b1;
          wptr_nxt = wptr_r + 1'b1;
          if (seen_r < TW'(trps_pkg::LINE_DEPTH)) begin
            seen_nxt = seen_r + 1'b1;
          end
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign push_op.diff = diff_r;
  assign push_op.sor  = sor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      first_r <= '0;
      seen_r  <= '0;
      wptr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      seen_r  <= seen_nxt;
      wptr_r  <= wptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    diff_r <= diff_nxt;
    sor_r  <= sor_nxt;
    sel_r  <= sel_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr_r] <= x_r;
    end
    rdata_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hdl/trps_fifo.sv]
// Short queue of tap differences between the front end and the shaper core.
// Depends on trps_pkg.
`default_nettype none

module trps_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  trps_pkg::op_t  push_op,
  output logic           pop_valid,
  input  logic           pop_ready,
  output trps_pkg::op_t  pop_op
);

  localparam int AW = trps_pkg::FIFO_AW;

  trps_pkg::op_t  entry [trps_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wr_r, wr_nxt;
  logic [AW-1:0]  rd_r, rd_nxt;
  logic [AW:0]    count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != (AW+1)'(trps_pkg::FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_op     = entry[rd_r];

  always_comb begin
    wr_nxt    = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt    = do_pop ? rd_r + 1'b1 : rd_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

[hdl/trps_back.sv]
// Shaper core: pulse and shaper accumulators, gain multiply and output register.
// Depends on trps_pkg and trps_out_if.
`default_nettype none

module trps_back (
  input  logic            clk,
  input  logic            rst_n,
  input  trps_pkg::cfg_t  cfg,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  trps_pkg::op_t   pop_op,
  trps_out_if.source      out_ch
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_ACC  = 3'd1;
  localparam logic [2:0] B_INC  = 3'd2;
  localparam logic [2:0] B_SHP  = 3'd3;
  localparam logic [2:0] B_MUL  = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  localparam int DW  = trps_pkg::DIFF_W;
  localparam int PW  = trps_pkg::P_W;
  localparam int SW  = trps_pkg::S_W;
  localparam int IW  = trps_pkg::INC_W;
  localparam int YW  = trps_pkg::Y_W;
  localparam int HW  = trps_pkg::MHI_W;
  localparam int LW  = trps_pkg::MLO_W;
  localparam int QW  = HW + 1;

  localparam logic signed [PW-1:0] P_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [YW-1:0] Y_MAX = {1'b0, {(YW-1){1'b1}}};
  localparam logic signed [YW-1:0] Y_MIN = {1'b1, {(YW-1){1'b0}}};

  logic [2:0]                       state_r, state_nxt;
  logic signed [DW-1:0]             diff_r;
  logic                             sor_r;
  logic signed [PW-1:0]             p_r;
  logic signed [SW-1:0]             s_r;
  logic signed [trps_pkg::PROD_W-1:0] prod_r;
  logic signed [IW-1:0]             inc_r;
  logic signed [HW-1:0]             mhi_r;
  logic [LW-1:0]                    mlo_r;
  logic                             sat_r;
  logic                             out_valid_r;
  logic signed [YW-1:0]             out_shaped_r;
  logic                             out_sat_r;

  logic signed [PW-1:0]             p_base;
  logic signed [PW:0]               p_sum;
  logic                             p_clip;
  logic signed [PW-1:0]             p_new;
  logic signed [trps_pkg::PROD_W-1:0] prod;
  logic signed [IW-1:0]             inc;
  logic signed [SW-1:0]             s_base;
  logic signed [SW:0]               s_sum;
  logic                             s_clip;
  logic signed [SW-1:0]             s_new;
  logic signed [HW-1:0]             mhi;
  logic [LW-1:0]                    mlo;
  logic signed [QW-1:0]             y_sum;
  logic [QW-YW:0]                   y_top;
  logic                             y_clip;
  logic signed [YW-1:0]             y_new;
  logic                             out_free;

  assign p_base = sor_r ? '0 : p_r;
  assign p_sum  = (PW+1)'(p_base) + (PW+1)'(diff_r);
  assign p_clip = (p_sum[PW] != p_sum[PW-1]);
  assign p_new  = p_clip ? (p_sum[PW] ? P_MIN : P_MAX) : p_sum[PW-1:0];

  assign prod = diff_r * $signed({1'b0, cfg.decay});

  assign inc = cfg.step ? IW'($signed({diff_r, 8'b0}))
                        : IW'($signed({p_r, 8'b0})) + IW'(prod_r);

  assign s_base = sor_r ? '0 : s_r;
  assign s_sum  = (SW+1)'(s_base) + (SW+1)'(inc_r);
  assign s_clip = (s_sum[SW] != s_sum[SW-1]);
  assign s_new  = s_clip ? (s_sum[SW] ? S_MIN : S_MAX) : s_sum[SW-1:0];

  assign mhi = $signed(s_r[SW-1:32]) * $signed({1'b0, cfg.gain});
  assign mlo = LW'(s_r[31:0]) * LW'(cfg.gain);

  assign y_sum  = QW'(mhi_r) + QW'($signed({1'b0, mlo_r[LW-1:32]}));
  assign y_top  = y_sum[QW-1:YW-1];
  assign y_clip = !((&y_top) || (~|y_top));
  assign y_new  = y_clip ? (y_sum[QW-1] ? Y_MIN : Y_MAX) : y_sum[YW-1:0];

  assign out_free  = !out_valid_r || out_ch.ready;
  assign pop_ready = (state_r == B_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (pop_valid) state_nxt = B_ACC;
      B_ACC:   state_nxt = B_INC;
      B_INC:   state_nxt = B_SHP;
      B_SHP:   state_nxt = B_MUL;
      B_MUL:   state_nxt = B_OUT;
      B_OUT:   if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      p_r         <= '0;
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_ACC) begin
        p_r <= p_new;
      end
      if (state_r == B_SHP) begin
        s_r <= s_new;
      end
      if (state_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && pop_valid) begin
      diff_r <= pop_op.diff;
      sor_r  <= pop_op.sor;
    end
    if (state_r == B_ACC) begin
      prod_r <= prod;
      sat_r  <= p_clip;
    end
    if (state_r == B_INC) begin
      inc_r <= inc;
    end
    if (state_r == B_SHP) begin
      sat_r <= sat_r | s_clip;
    end
    if (state_r == B_MUL) begin
      mhi_r <= mhi;
      mlo_r <= mlo;
    end
    if (state_r == B_OUT && out_free) begin
      out_shaped_r <= y_new;
      out_sat_r    <= sat_r | y_clip;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.shaped    = out_shaped_r;
  assign out_ch.saturated = out_sat_r;

endmodule

`default_nettype wire

[hdl/trapezoidal_pulse_shaper.sv]
// The front end takes no new sample until the last one is pushed: it spends accept, three serial
// tap reads on the delay line's single read port, a final add and a push, which waits while the
// queue is full; the core runs accumulate, increment, shape, multiply and output steps.
// Reset (synchronous, rst_n low): registers return to defaults, accumulators,
// counters and queue clear; the delay line is not cleared and no pass is run.
`default_nettype none

module trapezoidal_pulse_shaper (
  input  logic                               clk,
  input  logic                               rst_n,
  trps_in_if.sink                            in_ch,
  trps_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [trps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  trps_pkg::cfg_t cfg_r;
  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  trps_pkg::op_t  push_op, pop_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise  <= trps_pkg::RISE_RST;
      cfg_r.gap   <= trps_pkg::GAP_RST;
      cfg_r.decay <= trps_pkg::DECAY_RST;
      cfg_r.step  <= 1'b0;
      cfg_r.gain  <= trps_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trps_pkg::CFG_RISE:  cfg_r.rise  <= cfg_data[trps_pkg::LEN_W-1:0];
        trps_pkg::CFG_GAP:   cfg_r.gap   <= cfg_data[trps_pkg::LEN_W-1:0];
        trps_pkg::CFG_DECAY: cfg_r.decay <= cfg_data[trps_pkg::M_W-1:0];
        trps_pkg::CFG_STEP:  cfg_r.step  <= cfg_data[0];
        trps_pkg::CFG_GAIN:  cfg_r.gain  <= cfg_data[trps_pkg::G_W-1:0];
        default: ;
      endcase
    end
  end

  trps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  trps_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  trps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[hdl/trps_checker.sv]
// Port-level checks of the trapezoidal pulse shaper, bound to the top level.
// Depends on assert_macros.svh and trps_pkg.
`default_nettype none
`include "assert_macros.svh"

module trps_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [trps_pkg::Y_W-1:0]      out_shaped,
  input logic                          out_saturated
);

  `TRPS_ASSERT(a_ready_drops, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready held after accept")
  `TRPS_ASSERT_NR(a_reset_clears, clk, !rst_n |=> !out_valid, "result valid after reset")
  `TRPS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_shaped) && $stable(out_saturated), "stalled result changed")

endmodule

bind trapezoidal_pulse_shaper trps_checker u_trps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_shaped    (out_ch.shaped),
  .out_saturated (out_ch.saturated)
);

`default_nettype wire
